// ===== src/mbe_pkg.sv =====
// shared types, constants and the colour palette of the escape-time pixel unit
// no dependencies; every other file imports this package
`default_nettype none

package mbe_pkg;

  // image and number formats
  localparam int ImageSize = 4096;
  localparam int CoordW    = $clog2(ImageSize);
  localparam int FracBits  = 28;
  localparam int IterW     = 16;
  localparam int ColourW   = 8;
  localparam int InsideEntry = 16;

  // stream payload widths, rounded up to whole bytes
  localparam int InDataW  = ((2 * CoordW + 7) / 8) * 8;
  localparam int OutDataW = ((2 * CoordW + IterW + 3 * ColourW + 7) / 8) * 8;

  // point queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_REAL_MIN  = 3'd0,
    REG_IMAG_MIN  = 3'd1,
    REG_STEP_RE   = 3'd2,
    REG_STEP_IM   = 3'd3,
    REG_ITER_LIM  = 3'd4,
    REG_ESC_BOUND = 3'd5
  } reg_idx_e;

  // register file contents
  typedef struct packed {
    logic [31:0]      real_min;
    logic [31:0]      imag_min;
    logic [30:0]      step_re;
    logic [30:0]      step_im;
    logic [IterW-1:0] iter_limit;
    logic [30:0]      esc_bound;
  } cfg_t;

  // one classified point handed from front to back
  typedef struct packed {
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic [31:0]       cx;
    logic [31:0]       cy;
  } point_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic             busy;
    logic [IterW-1:0] count;
  } core_status_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL_X,
    F_MUL_Y,
    F_ADD_Y,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_CHECK,
    C_UPDATE,
    C_MUL_XX,
    C_MUL_YY,
    C_MUL_XY,
    C_EMIT
  } core_state_e;

  // palette, returned as {blue, green, red}
  function automatic logic [3*ColourW-1:0] palette_rgb(input logic [4:0] sel);
    logic [3*ColourW-1:0] rgb;
    case (sel)
      5'd0:    rgb = {8'd15,  8'd30,  8'd66};
      5'd1:    rgb = {8'd26,  8'd7,   8'd25};
      5'd2:    rgb = {8'd47,  8'd1,   8'd9};
      5'd3:    rgb = {8'd73,  8'd4,   8'd4};
      5'd4:    rgb = {8'd100, 8'd7,   8'd0};
      5'd5:    rgb = {8'd138, 8'd44,  8'd12};
      5'd6:    rgb = {8'd177, 8'd82,  8'd24};
      5'd7:    rgb = {8'd209, 8'd125, 8'd57};
      5'd8:    rgb = {8'd229, 8'd181, 8'd134};
      5'd9:    rgb = {8'd248, 8'd236, 8'd211};
      5'd10:   rgb = {8'd191, 8'd233, 8'd241};
      5'd11:   rgb = {8'd95,  8'd201, 8'd248};
      5'd12:   rgb = {8'd0,   8'd170, 8'd255};
      5'd13:   rgb = {8'd0,   8'd128, 8'd204};
      5'd14:   rgb = {8'd0,   8'd87,  8'd153};
      5'd15:   rgb = {8'd3,   8'd52,  8'd106};
      5'd16:   rgb = {8'd16,  8'd16,  8'd16};
      default: rgb = {8'd16,  8'd16,  8'd16};
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

// ===== src/mandelbrot_escape_time_pixel_unit.sv =====
// top level: register file, front end, point queue and iteration core
// depends on mbe_pkg, mbe_front, mbe_queue, mbe_core
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: pixel_x, pixel_y
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: out_x, out_y, iterations, r, g, b
// apb       in   psel, penable, pwrite, pready   paddr 4*index, 32-bit data
//
// the front end takes one pixel at a time; it can hold one point while two more wait in the queue
// the core works on one pixel at a time: each iteration needs three
// products on the one shared 32x32 multiplier plus an escape check and an update step
// reset is asynchronous and active low; the configuration registers come back to their default window
// a waiting result sits in the output register while the core starts the next point
`default_nettype none

module mandelbrot_escape_time_pixel_unit
  import mbe_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // pixel requests
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // pixel_x, pixel_y
  // results
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // out_x, out_y, iterations, red, green, blue
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  cfg_t          cfg_q;
  reg_idx_e      reg_idx;
  logic          cfg_write;
  logic          q_push, q_pop;
  point_t        q_in, q_out;
  queue_status_t q_status;
  core_status_t  core_status;

  logic [CoordW-1:0]  res_x, res_y;
  logic [IterW-1:0]   res_iter;
  logic [ColourW-1:0] res_r, res_g, res_b;

  // register file
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.real_min   <= 32'hd800_0000;
      cfg_q.imag_min   <= 32'he000_0000;
      cfg_q.step_re    <= 31'd262144;
      cfg_q.step_im    <= 31'd262144;
      cfg_q.iter_limit <= 16'd200;
      cfg_q.esc_bound  <= 31'd1073741824;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_REAL_MIN:  cfg_q.real_min   <= pwdata;
        REG_IMAG_MIN:  cfg_q.imag_min   <= pwdata;
        REG_STEP_RE:   cfg_q.step_re    <= pwdata[30:0];
        REG_STEP_IM:   cfg_q.step_im    <= pwdata[30:0];
        REG_ITER_LIM:  cfg_q.iter_limit <= pwdata[IterW-1:0];
        REG_ESC_BOUND: cfg_q.esc_bound  <= pwdata[30:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_REAL_MIN:  prdata = cfg_q.real_min;
      REG_IMAG_MIN:  prdata = cfg_q.imag_min;
      REG_STEP_RE:   prdata = {1'b0, cfg_q.step_re};
      REG_STEP_IM:   prdata = {1'b0, cfg_q.step_im};
      REG_ITER_LIM:  prdata = 32'(cfg_q.iter_limit);
      REG_ESC_BOUND: prdata = {1'b0, cfg_q.esc_bound};
      default:       prdata = '0;
    endcase
  end

  mbe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_px_i    (s_axis_tdata[CoordW-1:0]),
    .in_py_i    (s_axis_tdata[2*CoordW-1:CoordW]),
    .full_i     (q_status.full),
    .push_o     (q_push),
    .point_o    (q_in)
  );

  mbe_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .data_i   (q_in),
    .pop_i    (q_pop),
    .data_o   (q_out),
    .status_o (q_status)
  );

  mbe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (q_status.empty),
    .pop_o       (q_pop),
    .point_i     (q_out),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_x_o     (res_x),
    .out_y_o     (res_y),
    .out_iter_o  (res_iter),
    .out_red_o   (res_r),
    .out_green_o (res_g),
    .out_blue_o  (res_b),
    .status_o    (core_status)
  );

  // result packing, lowest field first
  assign m_axis_tdata = OutDataW'({res_b, res_g, res_r, res_iter, res_y, res_x});

`ifndef SYNTHESIS
  // the front end never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_status.full)
    else $error("point pushed into full queue");

  // the core never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_status.empty)
    else $error("point popped from empty queue");

  // the iteration count stays within the limit while a point is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_status.busy |-> (core_status.count <= cfg_q.iter_limit))
    else $error("iteration count beyond limit");

  // a pop starts the core on the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |=> core_status.busy)
    else $error("core idle after taking a point");
`endif

endmodule

`default_nettype wire

// ===== src/mbe_front.sv =====
// front end: takes a pixel request, maps it to its complex point and queues it
// depends on mbe_pkg
`default_nettype none

module mbe_front
  import mbe_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CoordW-1:0] in_px_i,
  input  wire logic [CoordW-1:0] in_py_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output point_t                 point_o
);

  localparam int ProdW = CoordW + 31;
  localparam int SumW  = ProdW + 2;

  front_state_e state_q, state_d;

  logic [CoordW-1:0] px_q, py_q;
  logic [ProdW-1:0]  prod_q;
  logic [31:0]       cx_q, cy_q;

  logic [CoordW-1:0] mul_a;
  logic [30:0]       mul_b;
  logic [ProdW-1:0]  mul_p;
  logic [31:0]       edge_min;
  logic [SumW-1:0]   coord_sum;
  logic [31:0]       coord_sat;
  logic [31:0]       cy_abs;
  logic [32:0]       cy_twice;
  logic              cy_small;

  // saturate a wide signed sum to 32 bits
  function automatic logic [31:0] sat_to_32(input logic [SumW-1:0] v);
    logic [31:0] r;
    if (!v[SumW-1] && (|v[SumW-2:31])) begin
      r = 32'h7fff_ffff;
    end else if (v[SumW-1] && !(&v[SumW-2:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // shared coordinate multiplier, x first then y
  assign mul_a = (state_q == F_MUL_X) ? px_q : py_q;
  assign mul_b = (state_q == F_MUL_X) ? cfg_i.step_re : cfg_i.step_im;
  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  // window edge plus scaled index
  assign edge_min  = (state_q == F_ADD_Y) ? cfg_i.imag_min : cfg_i.real_min;
  assign coord_sum = {2'b00, prod_q} + {{(SumW-32){edge_min[31]}}, edge_min};
  assign coord_sat = sat_to_32(coord_sum);

  // imaginary part within half a pixel of the axis
  assign cy_abs   = cy_q[31] ? (32'd0 - cy_q) : cy_q;
  assign cy_twice = {cy_abs, 1'b0};
  assign cy_small = cy_twice < {2'b00, cfg_i.step_im};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          px_q <= in_px_i;
          py_q <= in_py_i;
        end
      end
      F_MUL_X: begin
        prod_q <= mul_p;
      end
      F_MUL_Y: begin
        cx_q   <= coord_sat;
        prod_q <= mul_p;
      end
      F_ADD_Y: begin
        cy_q <= coord_sat;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    case (state_q)
      F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = F_MUL_X;
      end
      F_MUL_X: state_d = F_MUL_Y;
      F_MUL_Y: state_d = F_ADD_Y;
      F_ADD_Y: state_d = F_PUSH;
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign point_o.px = px_q;
  assign point_o.py = py_q;
  assign point_o.cx = cx_q;
  assign point_o.cy = cy_small ? 32'd0 : cy_q;

endmodule

`default_nettype wire

// ===== src/mbe_queue.sv =====
// short point queue that decouples the front end from the iteration core
// depends on mbe_pkg
`default_nettype none

module mbe_queue
  import mbe_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire point_t data_i,
  input  wire logic   pop_i,
  output point_t      data_o,
  output queue_status_t status_o
);

  point_t entry_q [QueueDepth];

  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  function automatic logic [QPtrW-1:0] ptr_next(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= data_i;
  end

  assign data_o         = entry_q[rd_ptr_q];
  assign status_o.full  = (count_q == QCntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);

endmodule

`default_nettype wire

// ===== src/mbe_core.sv =====
// iteration core: runs z = z*z + c on one shared 32x32 multiplier, looks up the colour
// depends on mbe_pkg
`default_nettype none

module mbe_core
  import mbe_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cfg_t   cfg_i,
  input  wire logic   empty_i,
  output logic        pop_o,
  input  wire point_t point_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic [CoordW-1:0]  out_x_o,
  output logic [CoordW-1:0]  out_y_o,
  output logic [IterW-1:0]   out_iter_o,
  output logic [ColourW-1:0] out_red_o,
  output logic [ColourW-1:0] out_green_o,
  output logic [ColourW-1:0] out_blue_o,
  output core_status_t       status_o
);

  localparam logic [63:0] Max64 = {1'b0, {63{1'b1}}};
  localparam logic [63:0] Min64 = {1'b1, {63{1'b0}}};

  core_state_e state_q, state_d;

  logic [CoordW-1:0] px_q, py_q;
  logic [31:0]       cx_q, cy_q;
  logic [31:0]       zx_q, zy_q;
  logic [63:0]       zx2_q, zy2_q, pxy_q, diff_q;
  logic [IterW-1:0]  count_q;

  logic              ov_q;
  logic [CoordW-1:0] ox_q, oy_q;
  logic [IterW-1:0]  oiter_q;
  logic [3*ColourW-1:0] orgb_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [63:0] cx_wide, cy_wide;
  logic [64:0] mag_sum;
  logic [64:0] bound;
  logic        keep_going;
  logic [63:0] ny, nx;
  logic [4:0]  sel;
  logic        load_out;

  // saturating signed add
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    logic [63:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      r = s[64] ? Min64 : Max64;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  // saturating doubling
  function automatic logic [63:0] sat_double64(input logic [63:0] a);
    logic [63:0] r;
    if (a[63] != a[62]) begin
      r = a[63] ? Min64 : Max64;
    end else begin
      r = {a[62:0], 1'b0};
    end
    return r;
  endfunction

  // q8.56 to q4.28: floor, then saturate to 32 bits
  function automatic logic [31:0] narrow(input logic [63:0] t);
    logic [31:0] r;
    if (!t[63] && (|t[62:59])) begin
      r = 32'h7fff_ffff;
    end else if (t[63] && !(&t[62:59])) begin
      r = 32'h8000_0000;
    end else begin
      r = t[59:28];
    end
    return r;
  endfunction

  // shared multiplier, operands picked by phase
  always_comb begin
    case (state_q)
      C_MUL_XX: begin
        mul_a = zx_q;
        mul_b = zx_q;
      end
      C_MUL_YY: begin
        mul_a = zy_q;
        mul_b = zy_q;
      end
      default: begin
        mul_a = zx_q;
        mul_b = zy_q;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // escape test on the squares
  assign mag_sum    = {1'b0, zx2_q} + {1'b0, zy2_q};
  assign bound      = 65'({cfg_i.esc_bound, {FracBits{1'b0}}});
  assign keep_going = (count_q < cfg_i.iter_limit) && (mag_sum < bound);

  // next z in q8.56
  assign cx_wide = {{(32-FracBits){cx_q[31]}}, cx_q, {FracBits{1'b0}}};
  assign cy_wide = {{(32-FracBits){cy_q[31]}}, cy_q, {FracBits{1'b0}}};
  assign ny      = sat_add64(sat_double64(pxy_q), cy_wide);
  assign nx      = sat_add64(diff_q, cx_wide);

  // palette index
  assign sel      = (count_q == cfg_i.iter_limit) ? 5'(InsideEntry) : {1'b0, count_q[3:0]};
  assign load_out = (state_q == C_EMIT) && (!ov_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // iteration datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      C_IDLE: begin
        if (!empty_i) begin
          px_q    <= point_i.px;
          py_q    <= point_i.py;
          cx_q    <= point_i.cx;
          cy_q    <= point_i.cy;
          zx_q    <= '0;
          zy_q    <= '0;
          zx2_q   <= '0;
          zy2_q   <= '0;
          pxy_q   <= '0;
          diff_q  <= '0;
          count_q <= '0;
        end
      end
      C_UPDATE: begin
        zx_q    <= narrow(nx);
        zy_q    <= narrow(ny);
        count_q <= count_q + 1'b1;
      end
      C_MUL_XX: zx2_q <= mul_p;
      C_MUL_YY: zy2_q <= mul_p;
      C_MUL_XY: begin
        pxy_q  <= mul_p;
        diff_q <= zx2_q - zy2_q;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ox_q    <= px_q;
      oy_q    <= py_q;
      oiter_q <= count_q;
      orgb_q  <= palette_rgb(sel);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      C_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = C_CHECK;
        end
      end
      C_CHECK:  state_d = keep_going ? C_UPDATE : C_EMIT;
      C_UPDATE: state_d = C_MUL_XX;
      C_MUL_XX: state_d = C_MUL_YY;
      C_MUL_YY: state_d = C_MUL_XY;
      C_MUL_XY: state_d = C_CHECK;
      C_EMIT: begin
        if (load_out) state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  assign out_valid_o     = ov_q;
  assign out_x_o         = ox_q;
  assign out_y_o         = oy_q;
  assign out_iter_o      = oiter_q;
  assign out_red_o       = orgb_q[ColourW-1:0];
  assign out_green_o     = orgb_q[2*ColourW-1:ColourW];
  assign out_blue_o      = orgb_q[3*ColourW-1:2*ColourW];
  assign status_o.busy   = (state_q != C_IDLE);
  assign status_o.count  = count_q;

endmodule

`default_nettype wire

// ===== tb/mbe_pixel_scoreboard.sv =====
`timescale 1ns / 1ps
// scoreboard for the escape-time pixel unit: tracks the register settings on the
// configuration port, predicts each pixel result and checks the result stream
// depends on mbe_pkg for stream widths, coordinate format and register indexes

module mbe_pixel_scoreboard
  import mbe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // pixel request channel
  input  logic                pix_valid_i,
  input  logic                pix_ready_i,
  input  logic [InDataW-1:0]  pix_data_i,   // pixel_x, pixel_y
  // result channel
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  logic [OutDataW-1:0] res_data_i,   // out_x, out_y, iterations, red, green, blue
  // configuration port
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [4:0]          paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic [31:0]         prdata_i,
  // status towards the stimulus side
  output int                  pending_o,
  output int                  errors_o
);

  localparam longint Q56Max = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint Q56Min = -Q56Max - 1;
  localparam longint Q28Max = 64'sd2147483647;
  localparam longint Q28Min = -Q28Max - 1;
  localparam int     ReportLimit = 10;

  // register values after reset: window corner -2.5 - 2.0i, pixel 2^-10, 200 steps, radius^2 4.0
  localparam logic [31:0]      DefRealMin = 32'hD800_0000;
  localparam logic [31:0]      DefImagMin = 32'hE000_0000;
  localparam logic [30:0]      DefStep    = 31'd262144;
  localparam logic [IterW-1:0] DefLimit   = 16'd200;
  localparam logic [30:0]      DefBound   = 31'd1073741824;

  // colour table, entry i at bits [24*i +: 24] as {red, green, blue}; last entry is inside
  localparam logic [17*24-1:0] Palette = {
    {8'd16,  8'd16,  8'd16},  {8'd106, 8'd52,  8'd3},   {8'd153, 8'd87,  8'd0},
    {8'd204, 8'd128, 8'd0},   {8'd255, 8'd170, 8'd0},   {8'd248, 8'd201, 8'd95},
    {8'd241, 8'd233, 8'd191}, {8'd211, 8'd236, 8'd248}, {8'd134, 8'd181, 8'd229},
    {8'd57,  8'd125, 8'd209}, {8'd24,  8'd82,  8'd177}, {8'd12,  8'd44,  8'd138},
    {8'd0,   8'd7,   8'd100}, {8'd4,   8'd4,   8'd73},  {8'd9,   8'd1,   8'd47},
    {8'd25,  8'd7,   8'd26},  {8'd66,  8'd30,  8'd15}
  };
  localparam int PaletteCycle = 16;

  // result fields, msb first so that the struct maps straight onto tdata
  typedef struct packed {
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
    logic [IterW-1:0]  iters;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } pixel_result_t;

  logic signed [31:0] real_min;
  logic signed [31:0] imag_min;
  logic [30:0]        step_re;
  logic [30:0]        step_im;
  logic [IterW-1:0]   iter_limit;
  logic [30:0]        esc_bound;
  pixel_result_t      expected_pixels[$];
  int                 errors;

  function automatic longint clamp_q28(input longint v);
    if (v > Q28Max) return Q28Max;
    if (v < Q28Min) return Q28Min;
    return v;
  endfunction

  // saturating sum in Q8.56
  function automatic longint add_q56(input longint a, input longint b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s[64] != s[63]) return s[64] ? Q56Min : Q56Max;
    return longint'(s[63:0]);
  endfunction

  // iteration count of z = z^2 + c for one pixel under the current settings
  function automatic int unsigned escape_count(input logic [CoordW-1:0] px,
                                               input logic [CoordW-1:0] py);
    longint      c_re, c_im, c_re_w, c_im_w, bound;
    longint      z_re, z_im, sq_re, sq_im, next_re, next_im;
    int unsigned n;
    c_re = clamp_q28(longint'(real_min) + longint'(px) * longint'(step_re));
    c_im = clamp_q28(longint'(imag_min) + longint'(py) * longint'(step_im));
    // snap the imaginary part to the axis when within half a pixel of it
    if (2 * (c_im < 0 ? -c_im : c_im) < longint'(step_im)) c_im = 0;
    c_re_w = c_re <<< FracBits;
    c_im_w = c_im <<< FracBits;
    bound  = longint'(esc_bound) <<< FracBits;
    z_re   = 0;
    z_im   = 0;
    sq_re  = 0;
    sq_im  = 0;
    n      = 0;
    while (n < iter_limit && add_q56(sq_re, sq_im) < bound) begin
      next_im = add_q56(add_q56(z_re * z_im, z_re * z_im), c_im_w);
      next_re = add_q56(add_q56(sq_re, -sq_im), c_re_w);
      // arithmetic shift rounds toward minus infinity
      z_im  = clamp_q28(next_im >>> FracBits);
      z_re  = clamp_q28(next_re >>> FracBits);
      sq_re = z_re * z_re;
      sq_im = z_im * z_im;
      n++;
    end
    return n;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t want, got;
    logic [31:0]   reg_val;
    int unsigned   n_iter;
    int            sel;
    if (!rst_ni) begin
      real_min   = DefRealMin;
      imag_min   = DefImagMin;
      step_re    = DefStep;
      step_im    = DefStep;
      iter_limit = DefLimit;
      esc_bound  = DefBound;
      expected_pixels.delete();
      errors     = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      // configuration writes and read-back
      if (psel_i && penable_i && pready_i) begin
        reg_val = '0;
        case (paddr_i[4:2])
          REG_REAL_MIN:  reg_val = real_min;
          REG_IMAG_MIN:  reg_val = imag_min;
          REG_STEP_RE:   reg_val = {1'b0, step_re};
          REG_STEP_IM:   reg_val = {1'b0, step_im};
          REG_ITER_LIM:  reg_val = {16'd0, iter_limit};
          REG_ESC_BOUND: reg_val = {1'b0, esc_bound};
          default: ;
        endcase
        if (pwrite_i) begin
          case (paddr_i[4:2])
            REG_REAL_MIN:  real_min   = pwdata_i;
            REG_IMAG_MIN:  imag_min   = pwdata_i;
            REG_STEP_RE:   step_re    = pwdata_i[30:0];
            REG_STEP_IM:   step_im    = pwdata_i[30:0];
            REG_ITER_LIM:  iter_limit = pwdata_i[IterW-1:0];
            REG_ESC_BOUND: esc_bound  = pwdata_i[30:0];
            default: ;
          endcase
        end else if (paddr_i[4:2] <= REG_ESC_BOUND && prdata_i !== reg_val) begin
          errors++;
          if (errors <= ReportLimit)
            $display("%0t register at 0x%0h: expected 0x%08h, read 0x%08h",
                     $time, paddr_i, reg_val, prdata_i);
        end
      end

      // predict each accepted pixel request
      if (pix_valid_i && pix_ready_i) begin
        n_iter     = escape_count(pix_data_i[CoordW-1:0], pix_data_i[2*CoordW-1:CoordW]);
        sel        = (n_iter == iter_limit) ? InsideEntry : int'(n_iter % PaletteCycle);
        want.x     = pix_data_i[CoordW-1:0];
        want.y     = pix_data_i[2*CoordW-1:CoordW];
        want.iters = n_iter[IterW-1:0];
        {want.red, want.green, want.blue} = Palette[24*sel +: 24];
        expected_pixels.push_back(want);
      end

      // compare each accepted result with the oldest prediction
      if (res_valid_i && res_ready_i) begin
        got = pixel_result_t'(res_data_i);
        if (expected_pixels.size() == 0) begin
          errors++;
          if (errors <= ReportLimit)
            $display("%0t result for pixel (%0d,%0d) with no request outstanding",
                     $time, got.x, got.y);
        end else begin
          want = expected_pixels.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.iters !== want.iters ||
              got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
          begin
            errors++;
            if (errors <= ReportLimit)
              $display("%0t expected (%0d,%0d) iter %0d rgb %0d/%0d/%0d, got (%0d,%0d) %s",
                       $time, want.x, want.y, want.iters, want.red, want.green, want.blue,
                       got.x, got.y,
                       $sformatf("iter %0d rgb %0d/%0d/%0d",
                                 got.iters, got.red, got.green, got.blue));
          end
        end
      end

      pending_o <= expected_pixels.size();
      errors_o  <= errors;
    end
  end

endmodule

// ===== tb/tb_mandelbrot_escape_time_pixel_unit.sv =====
`timescale 1ns / 1ps
// testbench top for the escape-time pixel unit: clock, reset, register settings,
// bursty pixel requests, a stalling result sink and the verdict
// depends on mbe_pkg, mandelbrot_escape_time_pixel_unit and mbe_pixel_scoreboard

module tb_mandelbrot_escape_time_pixel_unit;
  import mbe_pkg::*;

  localparam int          QOne         = 268435456;      // 1.0 in Q4.28
  localparam logic [31:0] DefRealMin   = 32'hD800_0000;  // -2.5
  localparam logic [31:0] DefImagMin   = 32'hE000_0000;  // -2.0
  localparam logic [31:0] ViewImagMin  = 32'hE800_0000;  // -1.5
  localparam logic [30:0] DefStep      = 31'd262144;     // 2^-10
  localparam logic [30:0] DefBound     = 31'd1073741824; // 4.0
  localparam logic [30:0] MaxQ         = 31'h7FFF_FFFF;
  localparam logic [2:0]  RegSpare     = 3'd6;           // no register behind it
  localparam int          RandomPhases = 9;
  localparam int          PhaseItems   = 120;
  localparam int          SettleCycles = 50;
  localparam int          TimeoutNs    = 50_000_000;

  typedef enum {VIEW_SET, VIEW_WILD, VIEW_FAR} view_e;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [4:0]          paddr         = '0;
  logic [31:0]         pwdata        = '0;
  logic [31:0]         prdata;
  logic                pready;
  int                  pending;
  int                  mismatches;
  int                  burst_left    = 0;

  mandelbrot_escape_time_pixel_unit u_dut (.*);

  mbe_pixel_scoreboard u_pixel_scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_i (s_axis_tready),
    .pix_data_i  (s_axis_tdata),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .pending_o   (pending),
    .errors_o    (mismatches)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard limit on run time
  initial begin
    #(TimeoutNs);
    $display("[mandelbrot_escape_time_pixel_unit] ERROR");
    $finish;
  end

  // result sink: ready runs, chattering runs and stalls of varying length
  initial begin
    int run, stall;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(1, 60);
      if ($urandom_range(0, 3) == 0)
        repeat (run) @(negedge clk_i) m_axis_tready <= 1'($urandom_range(0, 1));
      else
        repeat (run) @(negedge clk_i) m_axis_tready <= 1'b1;
      stall = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
      repeat (stall) @(negedge clk_i) m_axis_tready <= 1'b0;
    end
  end

  // hold requests back until every outstanding pixel has come out
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // one register access: setup cycle, then access cycle until pready
  task automatic apb_access(input logic write, input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // new window and iteration settings, written only once the unit is empty
  task automatic configure(input logic [31:0] re_min, input logic [31:0] im_min,
                           input logic [30:0] pitch_re, input logic [30:0] pitch_im,
                           input logic [15:0] depth, input logic [30:0] radius_sq);
    int i;
    drain();
    apb_access(1'b1, REG_REAL_MIN, re_min);
    apb_access(1'b1, REG_IMAG_MIN, im_min);
    // unused upper bits carry noise, the unit must drop them
    apb_access(1'b1, REG_STEP_RE, {1'($urandom), pitch_re});
    apb_access(1'b1, REG_STEP_IM, {1'($urandom), pitch_im});
    apb_access(1'b1, REG_ITER_LIM, {16'($urandom), depth});
    apb_access(1'b1, REG_ESC_BOUND, {1'($urandom), radius_sq});
    apb_access(1'b1, RegSpare, $urandom);
    for (i = REG_REAL_MIN; i <= REG_ESC_BOUND; i++) apb_access(1'b0, 3'(i), '0);
  endtask

  // one pixel request, with bursts, gaps and the odd full drain in front of it
  task automatic send_pixel(input logic [CoordW-1:0] px, input logic [CoordW-1:0] py);
    int gap;
    if ($urandom_range(0, 149) == 0) drain();
    if (burst_left == 0) begin
      gap = $urandom_range(1, 25);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {py, px};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stimulus and verdict
  initial begin
    logic [31:0]       re_min, im_min;
    logic [30:0]       pitch_re, pitch_im, radius_sq;
    logic [15:0]       depth;
    logic [CoordW-1:0] px, py;
    view_e             view;
    int                p, i;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values, then corners and points inside the set on the default window
    for (i = REG_REAL_MIN; i <= REG_ESC_BOUND; i++) apb_access(1'b0, 3'(i), '0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd1536, 12'd2048);
    send_pixel(12'd2560, 12'd2048);

    // imaginary part a quarter pixel above the axis: snapped to zero
    configure(DefRealMin, DefImagMin + 32'd65536, DefStep, DefStep, 16'd64, DefBound);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd2048, 12'd2047);
    send_pixel(12'd1300, 12'd2048);

    // just under half a pixel below the axis: snapped to zero
    configure(DefRealMin, DefImagMin - 32'd131071, DefStep, DefStep, 16'd64, DefBound);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd2000, 12'd2049);

    // exactly half a pixel either side: kept
    configure(DefRealMin, DefImagMin + 32'd131072, DefStep, DefStep, 16'd64, DefBound);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd2048, 12'd2047);

    // zero iteration limit
    configure(DefRealMin, DefImagMin, DefStep, DefStep, 16'd0, DefBound);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd2048, 12'd2048);

    // zero escape bound, alone and with a zero limit
    configure(DefRealMin, DefImagMin, DefStep, DefStep, 16'd10, 31'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    configure(DefRealMin, DefImagMin, DefStep, DefStep, 16'd0, 31'd0);
    send_pixel(12'd5, 12'd5);

    // register extremes: saturated points, saturated magnitude sum, longest limit
    configure(32'h7FFF_FFFF, 32'h8000_0000, MaxQ, MaxQ, 16'hFFFF, MaxQ);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);

    // random windows: views of the set, wild settings, far outside with long limits
    for (p = 0; p < RandomPhases; p++) begin
      view = (p == 3 || p == 7) ? VIEW_FAR : (p == 1 || p == 5) ? VIEW_WILD : VIEW_SET;
      case (view)
        VIEW_SET: begin
          re_min    = DefRealMin + $urandom_range(0, QOne);
          im_min    = ViewImagMin + $urandom_range(0, QOne / 2);
          pitch_re  = 31'($urandom_range(1, 1 << 18));
          pitch_im  = 31'($urandom_range(1, 1 << 18));
          depth     = 16'($urandom_range(1, 48));
          radius_sq = ($urandom_range(0, 3) == 0) ? 31'($urandom) : DefBound;
        end
        VIEW_WILD: begin
          re_min    = $urandom;
          im_min    = $urandom;
          pitch_re  = 31'($urandom);
          pitch_im  = 31'($urandom);
          depth     = 16'($urandom_range(1, 64));
          radius_sq = 31'($urandom);
        end
        default: begin
          // real part at least 1.0, so every point escapes within a few steps
          re_min    = QOne + $urandom_range(0, 6 * QOne);
          im_min    = $urandom;
          pitch_re  = 31'($urandom_range(0, 1 << 20));
          pitch_im  = 31'($urandom);
          depth     = 16'($urandom_range(1000, 65535));
          radius_sq = DefBound;
        end
      endcase
      if (p == 3) depth = 16'hFFFF;
      if (p == 4) depth = 16'd1;
      if (p == 5) begin
        pitch_re = '0;
        pitch_im = '0;
      end
      configure(re_min, im_min, pitch_re, pitch_im, depth, radius_sq);
      repeat (PhaseItems) begin
        px = ($urandom_range(0, 7) == 0) ? {CoordW{1'($urandom)}} : CoordW'($urandom);
        py = ($urandom_range(0, 7) == 0) ? {CoordW{1'($urandom)}} : CoordW'($urandom);
        send_pixel(px, py);
      end
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0)
      $display("[mandelbrot_escape_time_pixel_unit] OK");
    else
      $display("[mandelbrot_escape_time_pixel_unit] ERROR");
    $finish;
  end

endmodule
